FILE: rtl/core/uer_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uer_pkg
// Types and constants shared by the ultrasonic echo ranger core.
// ----------------------------------------------------------------------------
package uer_pkg;

  localparam int unsigned TrigWidthW = 10;
  localparam int unsigned LimitW     = 16;
  localparam int unsigned CountW     = 17;
  localparam int unsigned DistW      = 14;
  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned CfgDataW   = 16;

  localparam logic [TrigWidthW-1:0] TrigWidthRst  = 10'd40;
  localparam logic [LimitW-1:0]     WaitLimitRst  = 16'd1176;
  localparam logic [LimitW-1:0]     WidthLimitRst = 16'd8000;

  localparam logic [CountW-1:0] CountMax = {CountW{1'b1}};

  // distance = floor(count * 17 / 100) = (count * DistMul) >> DistShift,
  // exact for every count below 2^17
  localparam int unsigned DistShift = 20;
  localparam int unsigned DistMulW  = 18;
  localparam logic [DistMulW-1:0] DistMul = 18'd178258;
  localparam int unsigned ProdW = CountW + DistMulW;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_TRIG = 2'd1,
    PH_WAIT = 2'd2,
    PH_MEAS = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NO_ECHO = 2'd1,
    ST_RANGE   = 2'd2
  } status_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_TRIG_WIDTH  = 2'd0,
    CFG_WAIT_LIMIT  = 2'd1,
    CFG_WIDTH_LIMIT = 2'd2,
    CFG_UNUSED      = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic             trig_front;
    logic             trig_rear;
    logic             busy;
    logic             done;
    status_e          status;
    logic [DistW-1:0] distance_mm;
  } result_t;

endpackage

FILE: rtl/core/ultrasonic_echo_ranger_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ultrasonic_echo_ranger_core
// Front/rear ultrasonic ranging controller, one microsecond tick per item.
// ----------------------------------------------------------------------------
// Usage:
//   Each input transfer (in_valid_i high, in_stall_o low) is one tick carrying
//   the echo pin levels and an optional start request. Every tick yields one
//   result transfer (out_valid_o high, out_stall_i low) with the trigger pin
//   levels, busy, done, status and distance in mm.
//   The phase, counter and a result or skid register update at the edge
//   that takes the tick; one tick per cycle while in_stall_o is low. The path
//   is a counter compare plus a 17x18 constant multiply for the distance.
//   When the receiver stalls, the held result stays on the outputs and one
//   more tick is taken into a skid register; in_stall_o rises only while that
//   skid register is full.
//   Configuration writes (cfg_valid_i, always ready) set trigger width, echo
//   wait limit and echo width limit; write them only while idle.
//   Reset returns to idle with the default register values and empties both
//   result registers.
// ----------------------------------------------------------------------------
module ultrasonic_echo_ranger_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         req_type_i,
  input  logic                         sensor_select_i,
  input  logic                         echo_front_i,
  input  logic                         echo_rear_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic                         trig_front_o,
  output logic                         trig_rear_o,
  output logic                         busy_res_o,
  output logic                         done_res_o,
  output logic [1:0]                   status_o,
  output logic [uer_pkg::DistW-1:0]    distance_mm_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [uer_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [uer_pkg::CfgDataW-1:0] cfg_data_i
);
  import uer_pkg::*;

  logic [TrigWidthW-1:0] trig_width_q;
  logic [LimitW-1:0]     wait_limit_q;
  logic [LimitW-1:0]     width_limit_q;

  phase_e              phase_q, phase_d;
  logic [CountW-1:0]   count_q, count_d;
  logic                sensor_q, sensor_d;

  logic                in_xfer;
  logic                out_xfer;
  logic                echo;
  logic [CountW-1:0]   count_inc;
  logic                trig;
  logic                done;
  status_e             status;
  logic [ProdW-1:0]    prod;
  result_t             res;

  logic                out_valid_q, skid_valid_q;
  result_t             out_q, skid_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trig_width_q  <= TrigWidthRst;
      wait_limit_q  <= WaitLimitRst;
      width_limit_q <= WidthLimitRst;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_TRIG_WIDTH:  trig_width_q  <= cfg_data_i[TrigWidthW-1:0];
        CFG_WAIT_LIMIT:  wait_limit_q  <= cfg_data_i[LimitW-1:0];
        CFG_WIDTH_LIMIT: width_limit_q <= cfg_data_i[LimitW-1:0];
        default: ;
      endcase
    end
  end

  assign in_stall_o = skid_valid_q;
  assign in_xfer    = in_valid_i && !skid_valid_q;
  assign out_xfer   = out_valid_q && !out_stall_i;

  assign echo      = sensor_q ? echo_rear_i : echo_front_i;
  assign count_inc = (count_q == CountMax) ? CountMax : count_q + 1'b1;
  assign prod      = count_q * DistMul;

  always_comb begin
    phase_d  = phase_q;
    count_d  = count_q;
    sensor_d = sensor_q;
    trig     = 1'b0;
    done     = 1'b0;
    status   = ST_OK;
    unique case (phase_q)
      PH_IDLE: begin
        if (req_type_i) begin
          sensor_d = sensor_select_i;
          phase_d  = PH_TRIG;
          count_d  = CountW'(1);
          trig     = 1'b1;
        end
      end
      PH_TRIG: begin
        if (count_q < CountW'(trig_width_q)) begin
          trig    = 1'b1;
          count_d = count_inc;
        end else begin
          phase_d = PH_WAIT;
          count_d = '0;
        end
      end
      PH_WAIT: begin
        if (echo) begin
          if (width_limit_q == '0) begin
            done    = 1'b1;
            status  = ST_RANGE;
            phase_d = PH_IDLE;
            count_d = '0;
          end else begin
            phase_d = PH_MEAS;
            count_d = CountW'(1);
          end
        end else if (count_inc > CountW'(wait_limit_q)) begin
          done    = 1'b1;
          status  = ST_NO_ECHO;
          phase_d = PH_IDLE;
          count_d = '0;
        end else begin
          count_d = count_inc;
        end
      end
      PH_MEAS: begin
        if (echo) begin
          if (count_inc > CountW'(width_limit_q)) begin
            done    = 1'b1;
            status  = ST_RANGE;
            phase_d = PH_IDLE;
            count_d = '0;
          end else begin
            count_d = count_inc;
          end
        end else begin
          done    = 1'b1;
          phase_d = PH_IDLE;
          count_d = '0;
        end
      end
      default: ;
    endcase

    res.trig_front  = trig && !sensor_d;
    res.trig_rear   = trig && sensor_d;
    res.busy        = (phase_d != PH_IDLE);
    res.done        = done;
    res.status      = status;
    res.distance_mm = (done && status == ST_OK) ?
                      prod[DistShift +: DistW] : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_IDLE;
      count_q  <= '0;
      sensor_q <= 1'b0;
    end else if (in_xfer) begin
      phase_q  <= phase_d;
      count_q  <= count_d;
      sensor_q <= sensor_d;
    end
  end

  // output register with one skid entry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (skid_valid_q) begin
        if (out_xfer) begin
          out_valid_q  <= 1'b1;
          skid_valid_q <= 1'b0;
        end
      end else if (in_xfer) begin
        if (out_valid_q && out_stall_i) begin
          skid_valid_q <= 1'b1;
        end else begin
          out_valid_q <= 1'b1;
        end
      end else if (out_xfer) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_xfer) begin
        out_q <= skid_q;
      end
    end else if (in_xfer) begin
      if (out_valid_q && out_stall_i) begin
        skid_q <= res;
      end else begin
        out_q <= res;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign trig_front_o  = out_q.trig_front;
  assign trig_rear_o   = out_q.trig_rear;
  assign busy_res_o    = out_q.busy;
  assign done_res_o    = out_q.done;
  assign status_o      = out_q.status;
  assign distance_mm_o = out_q.distance_mm;

  // skid entry only fills behind a held result
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry full without a held result");

  a_trig_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(trig_front_o && trig_rear_o))
    else $error("both triggers high");

  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && done_res_o) |-> !busy_res_o)
    else $error("busy after a finished measurement");

  a_err_no_distance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != ST_OK) |-> (distance_mm_o == '0 && done_res_o))
    else $error("error result with distance or without done");

endmodule

FILE: tb/ultrasonic_echo_ranger_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ultrasonic_echo_ranger_core_tb
// Self-checking bench for the ultrasonic echo ranger core. Ticks are shaped
// into trigger, echo wait and echo high sequences for both sensors, with
// stray starts and noise mixed in, under several register settings. Both
// channels idle at random and the receiver holds off once for a long stretch.
// Every result is predicted per tick and compared field by field.
// ----------------------------------------------------------------------------
module ultrasonic_echo_ranger_core_tb;
  import uer_pkg::*;

  localparam int unsigned IdleLimit  = 5000;
  localparam int unsigned HoldCycles = 300;
  localparam int unsigned RandTicks  = 860;

  class range_scoreboard;
    logic [TrigWidthW-1:0] trig_width;
    logic [LimitW-1:0]     wait_limit;
    logic [LimitW-1:0]     width_limit;
    phase_e                phase;
    logic [CountW-1:0]     count;
    logic                  active_rear;
    result_t               pending[$];
    int unsigned           mismatches;

    function new();
      trig_width  = 10'd40;
      wait_limit  = 16'd1176;
      width_limit = 16'd8000;
      phase       = PH_IDLE;
      count       = '0;
      active_rear = 1'b0;
      mismatches  = 0;
    endfunction

    function void set_reg(input cfg_idx_e idx, input logic [CfgDataW-1:0] data);
      case (idx)
        CFG_TRIG_WIDTH:  trig_width  = data[TrigWidthW-1:0];
        CFG_WAIT_LIMIT:  wait_limit  = data[LimitW-1:0];
        CFG_WIDTH_LIMIT: width_limit = data[LimitW-1:0];
        default: ;
      endcase
    endfunction

    function logic [CountW-1:0] bump(input logic [CountW-1:0] c);
      return (c == '1) ? c : c + 1'b1;
    endfunction

    function string fmt(input result_t r);
      return $sformatf("trig %b/%b busy %b done %b status %0d dist %0d",
                       r.trig_front, r.trig_rear, r.busy, r.done, r.status, r.distance_mm);
    endfunction

    // predict the result of one accepted tick
    function void note_tick(input logic req, input logic sel, input logic ef, input logic er);
      result_t r;
      logic    echo;
      logic    trig;
      r    = '0;
      trig = 1'b0;
      echo = active_rear ? er : ef;
      case (phase)
        PH_IDLE: begin
          if (req) begin
            active_rear = sel;
            phase       = PH_TRIG;
            count       = CountW'(1);
            trig        = 1'b1;
          end
        end
        PH_TRIG: begin
          if (count < trig_width) begin
            trig  = 1'b1;
            count = bump(count);
          end else begin
            phase = PH_WAIT;
            count = '0;
          end
        end
        PH_WAIT: begin
          if (echo) begin
            phase = PH_MEAS;
            count = CountW'(1);
            if (count > width_limit) begin
              r.done   = 1'b1;
              r.status = ST_RANGE;
              phase    = PH_IDLE;
              count    = '0;
            end
          end else begin
            count = bump(count);
            if (count > wait_limit) begin
              r.done   = 1'b1;
              r.status = ST_NO_ECHO;
              phase    = PH_IDLE;
              count    = '0;
            end
          end
        end
        default: begin
          if (echo) begin
            count = bump(count);
            if (count > width_limit) begin
              r.done   = 1'b1;
              r.status = ST_RANGE;
              phase    = PH_IDLE;
              count    = '0;
            end
          end else begin
            r.done        = 1'b1;
            r.status      = ST_OK;
            r.distance_mm = DistW'((32'(count) * 32'd17) / 32'd100);
            phase         = PH_IDLE;
            count         = '0;
          end
        end
      endcase
      r.trig_front = trig & ~active_rear;
      r.trig_rear  = trig & active_rear;
      r.busy       = (phase != PH_IDLE);
      pending.push_back(r);
    endfunction

    function void check_result(input result_t got);
      result_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result: %s", fmt(got));
        return;
      end
      want = pending.pop_front();
      if (got.trig_front !== want.trig_front || got.trig_rear !== want.trig_rear ||
          got.busy !== want.busy || got.done !== want.done ||
          got.status !== want.status || got.distance_mm !== want.distance_mm) begin
        mismatches++;
        if (mismatches <= 10) $display("mismatch: expected %s, got %s", fmt(want), fmt(got));
      end
    endfunction
  endclass

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic               req_type;
  logic               sensor_select;
  logic               echo_front;
  logic               echo_rear;
  logic               out_valid;
  logic               out_stall;
  logic               trig_front;
  logic               trig_rear;
  logic               busy_res;
  logic               done_res;
  logic [1:0]         status;
  logic [DistW-1:0]   distance_mm;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [CfgIdxW-1:0] cfg_index;
  logic [CfgDataW-1:0] cfg_data;

  range_scoreboard sb;
  bit              gaps_on;
  bit              hold_pending;
  int unsigned     ticks_sent;
  int unsigned     idle_cycles;

  ultrasonic_echo_ranger_core dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .req_type_i      (req_type),
    .sensor_select_i (sensor_select),
    .echo_front_i    (echo_front),
    .echo_rear_i     (echo_rear),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .trig_front_o    (trig_front),
    .trig_rear_o     (trig_rear),
    .busy_res_o      (busy_res),
    .done_res_o      (done_res),
    .status_o        (status),
    .distance_mm_o   (distance_mm),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data)
  );

  always #5 clk = ~clk;

  task automatic send_tick(input logic req, input logic sel, input logic ef, input logic er);
    if (gaps_on && $urandom_range(99) < 34) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid      <= 1'b1;
    req_type      <= req;
    sensor_select <= sel;
    echo_front    <= ef;
    echo_rear     <= er;
    do @(posedge clk); while (in_stall);
    sb.note_tick(req, sel, ef, er);
    ticks_sent++;
  endtask

  // drive the active sensor echo, the other one at random
  task automatic send_echo(input logic act, input logic level, input bit noisy);
    logic other;
    logic req;
    other = 1'($urandom_range(1));
    req   = noisy && ($urandom_range(99) < 15);
    if (act) send_tick(req, 1'($urandom_range(1)), other, level);
    else send_tick(req, 1'($urandom_range(1)), level, other);
  endtask

  task automatic run_measure(input logic sel, input int unsigned wait_n,
                             input int unsigned high_n, input int unsigned tail_n,
                             input bit noisy);
    int unsigned pre_n;
    pre_n = (sb.trig_width == 0) ? 1 : sb.trig_width;
    send_tick(1'b1, sel, 1'($urandom_range(1)), 1'($urandom_range(1)));
    repeat (pre_n) send_echo(sel, 1'($urandom_range(1)), noisy);
    repeat (wait_n) send_echo(sel, 1'b0, noisy);
    repeat (high_n) send_echo(sel, 1'b1, noisy);
    repeat (tail_n) send_echo(sel, 1'b0, noisy);
  endtask

  // finish any running measurement, then let every result drain
  task automatic settle();
    while (sb.phase != PH_IDLE)
      send_tick(1'b0, 1'b0, sb.phase == PH_WAIT, sb.phase == PH_WAIT);
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_regs(input logic [CfgDataW-1:0] tw, input logic [CfgDataW-1:0] wl,
                            input logic [CfgDataW-1:0] xl, input bit poke_unused);
    int       i;
    int       n;
    cfg_idx_e idx;
    n = poke_unused ? 4 : 3;
    cfg_valid <= 1'b1;
    for (i = 0; i < n; i++) begin
      idx = cfg_idx_e'(i);
      cfg_index <= idx;
      case (idx)
        CFG_TRIG_WIDTH:  cfg_data <= tw;
        CFG_WAIT_LIMIT:  cfg_data <= wl;
        CFG_WIDTH_LIMIT: cfg_data <= xl;
        default:         cfg_data <= CfgDataW'($urandom);
      endcase
      do @(posedge clk); while (!cfg_ready);
      sb.set_reg(idx, cfg_data);
    end
    cfg_valid <= 1'b0;
  endtask

  // receiver side: random stalls plus one long hold-off
  initial begin
    out_stall = 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (hold_pending) begin
        hold_pending = 1'b0;
        out_stall <= 1'b1;
        repeat (HoldCycles) @(posedge clk);
      end
      out_stall <= gaps_on && ($urandom_range(99) < 34);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall)
        sb.check_result('{trig_front: trig_front, trig_rear: trig_rear, busy: busy_res,
                          done: done_res, status: status_e'(status),
                          distance_mm: distance_mm});
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("timeout: no transfer for %0d cycles", IdleLimit);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin
    int unsigned     rand_start;
    int unsigned     p;
    int unsigned     n_meas;
    logic [CfgDataW-1:0] tw;
    logic [CfgDataW-1:0] wl;
    logic [CfgDataW-1:0] xl;
    clk           = 1'b0;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    req_type      = 1'b0;
    sensor_select = 1'b0;
    echo_front    = 1'b0;
    echo_rear     = 1'b0;
    cfg_valid     = 1'b0;
    cfg_index     = CFG_TRIG_WIDTH;
    cfg_data      = '0;
    gaps_on       = 1'b1;
    hold_pending  = 1'b0;
    ticks_sent    = 0;
    idle_cycles   = 0;
    sb            = new();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // idle ticks, then one measurement at the reset settings
    send_tick(1'b0, 1'b0, 1'b0, 1'b0);
    send_tick(1'b0, 1'b1, 1'b1, 1'b1);
    run_measure(1'b0, 5, 30, 2, 1'b0);
    settle();

    // zero trigger width and zero limits
    write_regs(16'd0, 16'd0, 16'd0, 1'b0);
    send_tick(1'b1, 1'b0, 1'b0, 1'b0);
    send_tick(1'b0, 1'b0, 1'b0, 1'b0);
    send_tick(1'b0, 1'b0, 1'b0, 1'b0);
    send_tick(1'b1, 1'b1, 1'b0, 1'b0);
    send_tick(1'b0, 1'b0, 1'b0, 1'b0);
    send_tick(1'b0, 1'b0, 1'b0, 1'b1);
    settle();

    // bits above the trigger width dropped, short limits
    write_regs(16'hFC01, 16'd2, 16'd3, 1'b0);
    send_tick(1'b1, 1'b0, 1'b0, 1'b0);
    send_tick(1'b1, 1'b1, 1'b0, 1'b1);
    send_tick(1'b0, 1'b0, 1'b0, 1'b1);
    send_tick(1'b0, 1'b0, 1'b1, 1'b1);
    send_tick(1'b0, 1'b0, 1'b1, 1'b0);
    send_tick(1'b0, 1'b0, 1'b0, 1'b0);
    run_measure(1'b1, 3, 0, 1, 1'b0);
    // out of range with a start on the ending tick, then a fresh start
    send_tick(1'b1, 1'b0, 1'b0, 1'b0);
    send_tick(1'b0, 1'b0, 1'b0, 1'b0);
    send_tick(1'b0, 1'b0, 1'b1, 1'b0);
    send_tick(1'b0, 1'b0, 1'b1, 1'b0);
    send_tick(1'b0, 1'b0, 1'b1, 1'b0);
    send_tick(1'b1, 1'b1, 1'b1, 1'b0);
    send_tick(1'b1, 1'b1, 1'b0, 1'b0);
    settle();

    // largest limits
    write_regs(16'd48, 16'hFFFF, 16'hFFFF, 1'b0);
    run_measure(1'b1, 3, 200, 2, 1'b0);
    run_measure(1'b0, 0, 1, 1, 1'b0);
    settle();

    // smallest nonzero settings
    write_regs(16'd1, 16'd1, 16'd1, 1'b1);
    repeat (6)
      run_measure(1'($urandom_range(1)), $urandom_range(0, 3), $urandom_range(0, 4),
                  $urandom_range(1, 3), 1'($urandom_range(1)));
    settle();

    rand_start = ticks_sent;
    p = 0;
    while (ticks_sent - rand_start < RandTicks) begin
      gaps_on = !(p == 1 || p == 2);
      tw = {6'($urandom), 10'($urandom_range(0, 8))};
      wl = CfgDataW'($urandom_range(0, 15));
      xl = ($urandom_range(5) == 0) ? CfgDataW'($urandom_range(100, 250)) :
                                      CfgDataW'($urandom_range(0, 60));
      write_regs(tw, wl, xl, 1'b0);
      if (p == 0) hold_pending = 1'b1;
      n_meas = $urandom_range(4, 8);
      repeat (n_meas) begin
        if ($urandom_range(99) < 85)
          run_measure(1'($urandom_range(1)), $urandom_range(0, sb.wait_limit + 2),
                      $urandom_range(0, sb.width_limit + 3), $urandom_range(1, 4),
                      $urandom_range(3) == 0);
        else
          repeat ($urandom_range(1, 6))
            send_tick(1'($urandom_range(1)), 1'($urandom_range(1)),
                      1'($urandom_range(1)), 1'($urandom_range(1)));
      end
      settle();
      p++;
    end
    gaps_on = 1'b1;

    repeat (10) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/core/uer_pkg.sv
rtl/core/ultrasonic_echo_ranger_core.sv
tb/ultrasonic_echo_ranger_core_tb.sv
